@@ src/bchc_pkg.sv @@
// ----------------------------------------------------------------------------
// bchc_pkg: shared definitions for the button click / hold classifier
// Register map, reset values, event codes and the structs passed between the
// top level and the classifier core.
// ----------------------------------------------------------------------------
`default_nettype none

package bchc_pkg;

    // Field widths.
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int EVENT_W  = 3;
    localparam int STEP_W   = 3;
    localparam int COUNT_W  = 8;

    // Default number of hold tone steps.
    localparam int HOLD_STEPS_DEF = 5;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] REG_CLICK_WIN   = 3'd1;
    localparam logic [2:0] REG_LONG_PRESS  = 3'd2;
    localparam logic [2:0] REG_LONG_HOLD   = 3'd3;
    localparam logic [2:0] REG_TONE_START  = 3'd4;
    localparam logic [2:0] REG_TONE_STEP   = 3'd5;

    // Register reset values in milliseconds.
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd10;
    localparam logic [CFG_W-1:0] CLICK_WIN_RST  = 16'd300;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd400;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST  = 16'd3000;
    localparam logic [CFG_W-1:0] TONE_START_RST = 16'd500;
    localparam logic [CFG_W-1:0] TONE_STEP_RST  = 16'd500;

    // Event codes.
    localparam logic [EVENT_W-1:0] EV_NONE     = 3'd0;
    localparam logic [EVENT_W-1:0] EV_LEFT     = 3'd1;
    localparam logic [EVENT_W-1:0] EV_RIGHT    = 3'd2;
    localparam logic [EVENT_W-1:0] EV_NOCONN   = 3'd3;
    localparam logic [EVENT_W-1:0] EV_GSTART   = 3'd4;
    localparam logic [EVENT_W-1:0] EV_GEND     = 3'd5;
    localparam logic [EVENT_W-1:0] EV_POWEROFF = 3'd6;
    localparam logic [EVENT_W-1:0] EV_PAIRING  = 3'd7;

    // Timing configuration seen by the core.
    typedef struct packed {
        logic [CFG_W-1:0] lockout_ms;
        logic [CFG_W-1:0] click_window_ms;
        logic [CFG_W-1:0] long_press_ms;
        logic [CFG_W-1:0] long_hold_ms;
        logic [CFG_W-1:0] hold_tone_start_ms;
        logic [CFG_W-1:0] hold_tone_step_ms;
    } cfg_t;

    // One classified result.
    typedef struct packed {
        logic                clean_level;
        logic                gesture_active;
        logic [STEP_W-1:0]   tone_index;
        logic                tone_valid;
        logic [EVENT_W-1:0]  event_code;
    } res_t;

endpackage

`default_nettype wire

@@ src/bchc_core.sv @@
// ----------------------------------------------------------------------------
// bchc_core: debouncer and click / hold state machine
// Holds the classifier state and computes one result per sample; the state
// advances at each clock edge where step_en is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bchc_core #(
    parameter int HOLD_STEPS = bchc_pkg::HOLD_STEPS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire bchc_pkg::cfg_t               cfg,
    input  wire logic                         step_en,
    input  wire logic [bchc_pkg::TIME_W-1:0]  now_ms,
    input  wire logic                         button_level,
    input  wire logic                         link_connected,
    output bchc_pkg::res_t                    res
);

    localparam int TW = bchc_pkg::TIME_W;
    localparam int SW = bchc_pkg::STEP_W;
    localparam int CW = bchc_pkg::COUNT_W;
    localparam int FW = bchc_pkg::CFG_W;
    // Tone schedule: start + step * interval fits in FW + SW bits.
    localparam int NW = FW + SW;

    localparam logic [SW-1:0] HoldStepsW = SW'(HOLD_STEPS);
    localparam logic [CW-1:0] CountMax   = {CW{1'b1}};

    // State codes.
    localparam logic [1:0] ST_IDLE    = 2'd0;
    localparam logic [1:0] ST_DOWN    = 2'd1;
    localparam logic [1:0] ST_UP      = 2'd2;
    localparam logic [1:0] ST_GESTURE = 2'd3;

    logic          level_reg,   level_next;
    logic [TW-1:0] lock_reg,    lock_next;
    logic [1:0]    state_reg,   state_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [TW-1:0] press_reg,   press_next;
    logic [TW-1:0] release_reg, release_next;
    logic [SW-1:0] step_reg,    step_next;

    logic          edge_ok;
    logic          pressed;
    logic          released;
    logic [TW-1:0] since_lock;
    logic [TW-1:0] held;
    logic [TW-1:0] since_release;
    logic [NW-1:0] tone_at;
    logic [bchc_pkg::EVENT_W-1:0] ev;
    logic          tv;
    logic [SW-1:0] ti;

    // Lockout debouncer: an edge counts only once the lockout has run out.
    assign since_lock = now_ms - lock_reg;
    assign edge_ok    = (button_level != level_reg) &&
                        (since_lock >= TW'(cfg.lockout_ms));
    assign pressed    = edge_ok && button_level;
    assign released   = edge_ok && !button_level;
    assign level_next = edge_ok ? button_level : level_reg;
    assign lock_next  = edge_ok ? now_ms : lock_reg;

    // Elapsed times and the time at which the next tone step is due.
    assign held          = now_ms - press_reg;
    assign since_release = now_ms - release_reg;
    assign tone_at       = NW'(cfg.hold_tone_start_ms) +
                           NW'(step_reg) * NW'(cfg.hold_tone_step_ms);

    // Click / hold state machine.
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        press_next   = press_reg;
        release_next = release_reg;
        step_next    = step_reg;
        ev           = bchc_pkg::EV_NONE;
        tv           = 1'b0;
        ti           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (pressed) begin
                    count_next = '0;
                    press_next = now_ms;
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN: begin
                if (released) begin
                    if (count_reg != CountMax) begin
                        count_next = count_reg + 1'b1;
                    end
                    release_next = now_ms;
                    state_next   = ST_UP;
                end else if (count_reg == '0 && held > TW'(cfg.long_press_ms)) begin
                    ev         = bchc_pkg::EV_GSTART;
                    state_next = ST_GESTURE;
                end else if (count_reg != '0) begin
                    // Stepped hold tones while a later press is held.
                    if (held >= TW'(cfg.hold_tone_start_ms) && step_reg < HoldStepsW &&
                        held >= TW'(tone_at)) begin
                        tv        = 1'b1;
                        ti        = step_reg;
                        step_next = step_reg + 1'b1;
                    end
                    // Long hold commands after one or two clicks.
                    if (held > TW'(cfg.long_hold_ms)) begin
                        if (count_reg == CW'(1)) begin
                            ev         = bchc_pkg::EV_POWEROFF;
                            state_next = ST_IDLE;
                        end else if (count_reg == CW'(2)) begin
                            ev         = bchc_pkg::EV_PAIRING;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_UP: begin
                if (pressed) begin
                    press_next = now_ms;
                    step_next  = '0;
                    state_next = ST_DOWN;
                end else if (since_release > TW'(cfg.click_window_ms)) begin
                    if (count_reg == CW'(1)) begin
                        ev = link_connected ? bchc_pkg::EV_LEFT : bchc_pkg::EV_NOCONN;
                    end else if (count_reg == CW'(2)) begin
                        ev = link_connected ? bchc_pkg::EV_RIGHT : bchc_pkg::EV_NOCONN;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                if (released) begin
                    ev         = bchc_pkg::EV_GEND;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    // Result of this sample.
    always_comb begin
        res.event_code     = ev;
        res.tone_valid     = tv;
        res.tone_index     = ti;
        res.gesture_active = (state_next == ST_GESTURE);
        res.clean_level    = level_next;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg   <= 1'b0;
            lock_reg    <= '0;
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            press_reg   <= '0;
            release_reg <= '0;
            step_reg    <= '0;
        end else if (step_en) begin
            level_reg   <= level_next;
            lock_reg    <= lock_next;
            state_reg   <= state_next;
            count_reg   <= count_next;
            press_reg   <= press_next;
            release_reg <= release_next;
            step_reg    <= step_next;
        end
    end

    // The tone step never runs past the configured number of steps.
    a_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg <= HoldStepsW)
        else $error("hold step beyond the last tone step");

    // Waiting for the click window implies at least one counted click.
    a_up_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UP |-> count_reg != '0)
        else $error("click window open with no click counted");

    // State only moves on a processed sample.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(state_reg) && $stable(count_reg) && $stable(step_reg))
        else $error("classifier state changed without a sample");

endmodule

`default_nettype wire

@@ src/button_click_hold_classifier.sv @@
// A beat is captured in the input register and its result in the output register.
// Throughput: one input beat per cycle unless m_tready stalls the output; the state
// update of each sample is a single compare-and-select pass, so the next follows at once.
// The output register lets a new beat in while a result waits on m_tready.
// Reset (aresetn low, synchronous) clears the classifier state, empties both
// stages and loads the timing registers with their default values.
// ----------------------------------------------------------------------------
// button_click_hold_classifier: debounced click, gesture and hold detector
// Stream in timestamped button samples, stream out one classified event per
// sample; timing is set through an APB register port.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_hold_classifier #(
    parameter int HOLD_STEPS = bchc_pkg::HOLD_STEPS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input samples.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // now_ms[31:0], button_level, link_connected, zeros
    // Results.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // event_code[2:0], tone_valid, tone_index[2:0],
                                        // gesture_active, clean_level, zeros
    // Configuration.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int TW = bchc_pkg::TIME_W;
    localparam int FW = bchc_pkg::CFG_W;
    localparam int RW = $bits(bchc_pkg::res_t);

    bchc_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_index;

    logic           in_valid_reg;
    logic [TW-1:0]  in_now_reg;
    logic           in_level_reg;
    logic           in_link_reg;
    logic           out_valid_reg;
    bchc_pkg::res_t out_res_reg;
    bchc_pkg::res_t core_res;

    logic           s_beat;
    logic           advance;
    logic           step_en;

    // Register port: writes land on the access phase, reads are immediate.
    assign pready    = 1'b1;
    assign reg_index = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.lockout_ms         <= bchc_pkg::DEBOUNCE_RST;
            cfg_reg.click_window_ms    <= bchc_pkg::CLICK_WIN_RST;
            cfg_reg.long_press_ms      <= bchc_pkg::LONG_PRESS_RST;
            cfg_reg.long_hold_ms       <= bchc_pkg::LONG_HOLD_RST;
            cfg_reg.hold_tone_start_ms <= bchc_pkg::TONE_START_RST;
            cfg_reg.hold_tone_step_ms  <= bchc_pkg::TONE_STEP_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_index)
                bchc_pkg::REG_DEBOUNCE:   cfg_reg.lockout_ms         <= pwdata[FW-1:0];
                bchc_pkg::REG_CLICK_WIN:  cfg_reg.click_window_ms    <= pwdata[FW-1:0];
                bchc_pkg::REG_LONG_PRESS: cfg_reg.long_press_ms      <= pwdata[FW-1:0];
                bchc_pkg::REG_LONG_HOLD:  cfg_reg.long_hold_ms       <= pwdata[FW-1:0];
                bchc_pkg::REG_TONE_START: cfg_reg.hold_tone_start_ms <= pwdata[FW-1:0];
                bchc_pkg::REG_TONE_STEP:  cfg_reg.hold_tone_step_ms  <= pwdata[FW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read-back mux; addresses past the last register read as zero.
    always_comb begin
        case (reg_index)
            bchc_pkg::REG_DEBOUNCE:   prdata = 32'(cfg_reg.lockout_ms);
            bchc_pkg::REG_CLICK_WIN:  prdata = 32'(cfg_reg.click_window_ms);
            bchc_pkg::REG_LONG_PRESS: prdata = 32'(cfg_reg.long_press_ms);
            bchc_pkg::REG_LONG_HOLD:  prdata = 32'(cfg_reg.long_hold_ms);
            bchc_pkg::REG_TONE_START: prdata = 32'(cfg_reg.hold_tone_start_ms);
            bchc_pkg::REG_TONE_STEP:  prdata = 32'(cfg_reg.hold_tone_step_ms);
            default:                  prdata = '0;
        endcase
    end

    // Pipeline control: the input stage moves whenever the output register
    // is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign s_beat   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_beat) begin
                in_valid_reg <= 1'b1;
            end else if (step_en) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Input sample register.
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            in_now_reg   <= s_tdata[TW-1:0];
            in_level_reg <= s_tdata[TW];
            in_link_reg  <= s_tdata[TW+1];
        end
    end

    bchc_core #(
        .HOLD_STEPS (HOLD_STEPS)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg_reg),
        .step_en        (step_en),
        .now_ms         (in_now_reg),
        .button_level   (in_level_reg),
        .link_connected (in_link_reg),
        .res            (core_res)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(16-RW){1'b0}}, out_res_reg};

endmodule

`default_nettype wire
